// ===== rtl/core/bmfsb_pkg.sv =====
package bmfsb_pkg;

  // default limits of the frame store and window
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 7;

  // fixed field widths
  localparam int COORD_W = 8;
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 9;
  localparam int RAD_W   = 3;
  localparam int SIDE_W  = 5;
  localparam int IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_RADIUS = 2'd2;

  // register reset values before clamping
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST   = 9'd256;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST  = 9'd256;
  localparam logic [RAD_W-1:0] KERNEL_RADIUS_RST = 3'd1;

  // controller to datapath commands
  typedef struct packed {
    logic write;
    logic latch;
    logic setup;
    logic read_step;
    logic div_init;
    logic div_step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic oor;
    logic read_last;
    logic div_last;
  } sts_t;

  // window placement along one axis
  typedef struct packed {
    logic [DIM_W-1:0]  start;
    logic [SIDE_W-1:0] cnt;
  } win_t;

  // zero becomes one, values above the maximum saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = 9'd1;
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

  function automatic logic [RAD_W-1:0] clamp_rad(input logic [RAD_W-1:0] v, input int maxv);
    logic [RAD_W-1:0] res;
    res = v;
    if (int'(v) > maxv) begin
      res = RAD_W'(maxv);
    end
    return res;
  endfunction

  // window shifted inward at the borders, clipped when the image is small
  function automatic win_t win_place(input logic [DIM_W-1:0] pos, input logic [DIM_W-1:0] size,
                                     input logic [RAD_W-1:0] r, input logic [SIDE_W-1:0] side);
    win_t             w;
    logic [DIM_W-1:0] lim;
    logic [DIM_W-1:0] st;
    lim = size - DIM_W'(side);
    st  = (pos > DIM_W'(r)) ? pos - DIM_W'(r) : '0;
    if (size <= DIM_W'(side)) begin
      w.start = '0;
      w.cnt   = size[SIDE_W-1:0];
    end else begin
      w.start = (st > lim) ? lim : st;
      w.cnt   = side;
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/bmfsb_ctrl.sv =====
module bmfsb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  bmfsb_pkg::sts_t   sts,
  output bmfsb_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIVI  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);

  // commands to the datapath
  always_comb begin
    cmd.write     = accept && !func;
    cmd.latch     = accept && func;
    cmd.setup     = (state == S_SETUP);
    cmd.read_step = (state == S_READ);
    cmd.div_init  = (state == S_DIVI);
    cmd.div_step  = (state == S_DIV);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = sts.oor ? S_DONE : S_READ;
      end
      S_READ: begin
        if (sts.read_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DIVI;
      end
      S_DIVI: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_oor_skips: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && sts.oor) |=> done)
    else $error("out of range query did not go straight to result");
  a_read_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && sts.read_last) |=> state == S_DRAIN)
    else $error("window scan did not end after its last read");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_last) |=> state == S_DIV)
    else $error("divider left before its last step");
  a_no_req_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.write && !cmd.latch)
    else $error("request taken while busy");
`endif

endmodule

// ===== rtl/core/bmfsb_datapath.sv =====
module bmfsb_datapath #(
  parameter int MAX_WIDTH  = bmfsb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmfsb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bmfsb_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [bmfsb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bmfsb_pkg::DIM_W-1:0]     cfg_data,
  input  logic [bmfsb_pkg::COORD_W-1:0]   row,
  input  logic [bmfsb_pkg::COORD_W-1:0]   col,
  input  logic [bmfsb_pkg::PIX_W-1:0]     pixel,
  input  bmfsb_pkg::cmd_t                 cmd,
  output bmfsb_pkg::sts_t                 sts,
  output logic [15:0]                     mean_value,
  output logic                            out_of_range
);

  localparam int DIM_W    = bmfsb_pkg::DIM_W;
  localparam int SIDE_W   = bmfsb_pkg::SIDE_W;
  localparam int RW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW       = RW + CW;
  localparam int DEPTH    = 1 << AW;
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int DIV_MAX  = SIDE_MAX * SIDE_MAX;
  localparam int SUM_W    = $clog2(DIV_MAX * 255 + 1);
  localparam int DVS_W    = $clog2(DIV_MAX + 1);
  localparam int NUM_W    = SUM_W + 9;
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam int COORD_X  = bmfsb_pkg::COORD_W;

  // configuration registers
  logic [DIM_W-1:0]            img_w;
  logic [DIM_W-1:0]            img_h;
  logic [bmfsb_pkg::RAD_W-1:0] rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= bmfsb_pkg::clamp_dim(bmfsb_pkg::IMAGE_WIDTH_RST, MAX_WIDTH);
      img_h <= bmfsb_pkg::clamp_dim(bmfsb_pkg::IMAGE_HEIGHT_RST, MAX_HEIGHT);
      rad   <= bmfsb_pkg::clamp_rad(bmfsb_pkg::KERNEL_RADIUS_RST, MAX_RADIUS);
    end else if (cfg_valid) begin
      case (cfg_index)
        bmfsb_pkg::REG_IMAGE_WIDTH:   img_w <= bmfsb_pkg::clamp_dim(cfg_data, MAX_WIDTH);
        bmfsb_pkg::REG_IMAGE_HEIGHT:  img_h <= bmfsb_pkg::clamp_dim(cfg_data, MAX_HEIGHT);
        bmfsb_pkg::REG_KERNEL_RADIUS: rad <= bmfsb_pkg::clamp_rad(cfg_data[2:0], MAX_RADIUS);
        default: ;
      endcase
    end
  end

  // latched query coordinates
  logic [DIM_W-1:0] row_q;
  logic [DIM_W-1:0] col_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_q <= DIM_W'(row);
      col_q <= DIM_W'(col);
    end
  end

  // window placement
  logic [SIDE_W-1:0] side;
  bmfsb_pkg::win_t   wr;
  bmfsb_pkg::win_t   wc;
  logic              oor;

  assign side = {1'b0, rad, 1'b1};
  assign wr   = bmfsb_pkg::win_place(row_q, img_h, rad, side);
  assign wc   = bmfsb_pkg::win_place(col_q, img_w, rad, side);
  assign oor  = (row_q >= img_h) || (col_q >= img_w);

  logic [DIM_W-1:0]  r0;
  logic [DIM_W-1:0]  c0;
  logic [SIDE_W-1:0] nr;
  logic [SIDE_W-1:0] nc;
  logic [DVS_W-1:0]  dvs;
  logic              oor_q;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      r0    <= wr.start;
      nr    <= wr.cnt;
      nc    <= wc.cnt;
      c0    <= wc.start;
      dvs   <= DVS_W'(side) * DVS_W'(side);
      oor_q <= oor;
    end
  end

  // window scan counters
  logic [SIDE_W-1:0] ri;
  logic [SIDE_W-1:0] ci;
  logic              read_last;
  logic [DIM_W-1:0]  rr;
  logic [DIM_W-1:0]  cc;
  logic [RW+DIM_W-1:0] rr_x;
  logic [CW+DIM_W-1:0] cc_x;
  logic [AW-1:0]     raddr;

  assign read_last = (ri == nr - 1'b1) && (ci == nc - 1'b1);
  assign rr        = r0 + DIM_W'(ri);
  assign cc        = c0 + DIM_W'(ci);
  assign rr_x      = (RW + DIM_W)'(rr);
  assign cc_x      = (CW + DIM_W)'(cc);
  assign raddr     = {rr_x[RW-1:0], cc_x[CW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ri <= '0;
      ci <= '0;
    end else if (cmd.read_step) begin
      if (ci == nc - 1'b1) begin
        ci <= '0;
        ri <= ri + 1'b1;
      end else begin
        ci <= ci + 1'b1;
      end
    end
  end

  // frame store, one write or one read a cycle
  logic [7:0]            mem [DEPTH];
  logic [7:0]            rdata;
  logic                  wr_ok;
  logic [RW+COORD_X-1:0] wrow_x;
  logic [CW+COORD_X-1:0] wcol_x;
  logic [AW-1:0]         waddr;

  assign wr_ok  = (int'(row) < MAX_HEIGHT) && (int'(col) < MAX_WIDTH);
  assign wrow_x = (RW + COORD_X)'(row);
  assign wcol_x = (CW + COORD_X)'(col);
  assign waddr  = {wrow_x[RW-1:0], wcol_x[CW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[waddr] <= pixel;
    end else if (cmd.read_step) begin
      rdata <= mem[raddr];
    end
  end

  // accumulate the window sum one pixel a cycle
  logic             rd_valid;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sum <= '0;
    end else if (rd_valid) begin
      sum <= sum + SUM_W'(rdata);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [NUM_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [DVS_W:0]    rem_sub;

  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= {sum, 8'd0} + NUM_W'(dvs >> 1);
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[NUM_W-2:0], fits};
      rem  <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dcnt <= dcnt + 1'b1;
    end
  end

  // status and result
  always_comb begin
    sts.oor       = oor;
    sts.read_last = read_last;
    sts.div_last  = (dcnt == DCNT_W'(NUM_W - 1));
  end

  assign out_of_range = oor_q;
  assign mean_value   = oor_q ? 16'd0 :
                        (|quo[NUM_W-1:16]) ? 16'hFFFF : quo[15:0];

endmodule

// ===== rtl/core/box_mean_filter_shifted_border.sv =====
// Box mean filter over a stored grayscale frame. A request with func 0 writes
// one pixel into the frame store and completes in the cycle it is taken, with
// no result. A request with func 1 returns the sum of the (2r+1) square window
// around (row, col), shifted inward at the image edges and clipped when the
// image is smaller than the window, divided by (2r+1)^2 even when clipped, as
// unsigned Q8.8 rounded to nearest; a coordinate outside the configured image
// gives out_of_range with a zero mean. A query steps through the setup state,
// one frame store read per window pixel through the single memory port, the
// drain state, the divider load and one divider step per quotient bit, then
// the result state; an out of range query goes from setup straight to the
// result, skipping the reads and the divider. busy is high throughout. The
// result is on mean_value and out_of_range for the single cycle that done is
// high; the receiver cannot stall it and must take it then. The frame store is
// not cleared after reset: every pixel a query window covers must have been
// written first. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while the block is idle.
module box_mean_filter_shifted_border #(
  parameter int MAX_WIDTH  = bmfsb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmfsb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bmfsb_pkg::DEF_MAX_RADIUS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [bmfsb_pkg::COORD_W-1:0] row,
  input  logic [bmfsb_pkg::COORD_W-1:0] col,
  input  logic [bmfsb_pkg::PIX_W-1:0]   pixel,
  output logic                          done,
  output logic [15:0]                   mean_value,
  output logic                          out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmfsb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bmfsb_pkg::DIM_W-1:0]   cfg_data
);

  bmfsb_pkg::cmd_t cmd;
  bmfsb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  bmfsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // frame store, window scan and divider
  bmfsb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row          (row),
    .col          (col),
    .pixel        (pixel),
    .cmd          (cmd),
    .sts          (sts),
    .mean_value   (mean_value),
    .out_of_range (out_of_range)
  );

endmodule

// ===== tb/tb_box_mean_filter_shifted_border.sv =====
module tb_box_mean_filter_shifted_border;

  // widths and limits taken from the package
  localparam int IDX_W          = bmfsb_pkg::IDX_W;
  localparam int COORD_W        = bmfsb_pkg::COORD_W;
  localparam int PIX_W          = bmfsb_pkg::PIX_W;
  localparam int DIM_W          = bmfsb_pkg::DIM_W;
  localparam int RAD_W          = bmfsb_pkg::RAD_W;
  localparam int DEF_MAX_WIDTH  = bmfsb_pkg::DEF_MAX_WIDTH;
  localparam int DEF_MAX_HEIGHT = bmfsb_pkg::DEF_MAX_HEIGHT;
  localparam int DEF_MAX_RADIUS = bmfsb_pkg::DEF_MAX_RADIUS;

  // request codes and the register index that decodes to nothing
  localparam logic             FUNC_WRITE = 1'b0;
  localparam logic             FUNC_QUERY = 1'b1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 650;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [15:0] mean;
    logic        oor;
    int          qrow;
    int          qcol;
  } mean_result_t;

  typedef struct {
    int first;
    int extent;
  } span_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               func;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [PIX_W-1:0]   pixel;
  logic               done;
  logic [15:0]        mean_value;
  logic               out_of_range;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [DIM_W-1:0]   cfg_data;

  // shadow of the frame store and of the registers
  logic [PIX_W-1:0] frame_copy [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  bit               pixel_written [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  int               img_width;
  int               img_height;
  int               win_radius;

  mean_result_t pending_means[$];
  int           fault_count;
  int           requests_sent;
  int           writes_sent;
  int           queries_sent;
  int           oor_queries;
  int           cfg_writes;
  int           phases_run;
  bit           steady_stream;

  box_mean_filter_shifted_border dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .row          (row),
    .col          (col),
    .pixel        (pixel),
    .done         (done),
    .mean_value   (mean_value),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #12_000_000;
    $display("box_mean_filter_shifted_border verification failed");
    $finish;
  end

  // window placement along one axis, shifted inward, clipped on small images
  function automatic span_t axis_span(input int pos, input int size, input int rad);
    span_t s;
    int    side;
    side = 2 * rad + 1;
    if (size <= side) begin
      s.first  = 0;
      s.extent = size;
    end else begin
      s.first  = (pos > rad) ? pos - rad : 0;
      if (s.first > size - side) s.first = size - side;
      s.extent = side;
    end
    return s;
  endfunction

  // rounded Q8.8 mean over the window of the shadow frame
  function automatic mean_result_t window_mean(input int qr, input int qc);
    mean_result_t res;
    span_t        rs;
    span_t        cs;
    int           divisor;
    longint       total;
    longint       q;
    res.qrow = qr;
    res.qcol = qc;
    if (qr >= img_height || qc >= img_width) begin
      res.mean = '0;
      res.oor  = 1'b1;
      return res;
    end
    rs    = axis_span(qr, img_height, win_radius);
    cs    = axis_span(qc, img_width, win_radius);
    total = 0;
    for (int i = 0; i < rs.extent; i++) begin
      for (int j = 0; j < cs.extent; j++) begin
        total += frame_copy[(rs.first + i) * DEF_MAX_WIDTH + cs.first + j];
      end
    end
    divisor = (2 * win_radius + 1) * (2 * win_radius + 1);
    q       = (total * 256 + divisor / 2) / divisor;
    if (q > 65535) q = 65535;
    res.mean = q[15:0];
    res.oor  = 1'b0;
    return res;
  endfunction

  // one request: optional gap, then hold start until busy is low at an edge
  task automatic send_request(input logic op, input logic [COORD_W-1:0] r_c,
                              input logic [COORD_W-1:0] c_c, input logic [PIX_W-1:0] pix);
    int           gap;
    int           idx;
    mean_result_t res;
    gap = steady_stream ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func  <= op;
    row   <= r_c;
    col   <= c_c;
    pixel <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (op == FUNC_WRITE) begin
      idx                = int'(r_c) * DEF_MAX_WIDTH + int'(c_c);
      frame_copy[idx]    = pix;
      pixel_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      res = window_mean(int'(r_c), int'(c_c));
      pending_means.push_back(res);
      queries_sent++;
      if (res.oor) oor_queries++;
    end
  endtask

  // stop sending and wait until the block is idle with nothing outstanding
  task automatic settle();
    start <= 1'b0;
    while (pending_means.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      bmfsb_pkg::REG_IMAGE_WIDTH: begin
        img_width = (data == '0) ? 1 :
                    ((int'(data) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(data));
      end
      bmfsb_pkg::REG_IMAGE_HEIGHT: begin
        img_height = (data == '0) ? 1 :
                     ((int'(data) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(data));
      end
      bmfsb_pkg::REG_KERNEL_RADIUS: begin
        win_radius = (int'(data[RAD_W-1:0]) > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS :
                     int'(data[RAD_W-1:0]);
      end
      default: begin
      end
    endcase
  endtask

  // write every window pixel not yet stored, or all of them with one shade
  task automatic cover_window(input int qr, input int qc, input bit repaint,
                              input logic [PIX_W-1:0] shade);
    span_t rs;
    span_t cs;
    int    idx;
    rs = axis_span(qr, img_height, win_radius);
    cs = axis_span(qc, img_width, win_radius);
    for (int i = 0; i < rs.extent; i++) begin
      for (int j = 0; j < cs.extent; j++) begin
        idx = (rs.first + i) * DEF_MAX_WIDTH + cs.first + j;
        if (repaint || !pixel_written[idx]) begin
          send_request(FUNC_WRITE, COORD_W'(rs.first + i), COORD_W'(cs.first + j),
                       repaint ? shade : PIX_W'($urandom));
        end
      end
    end
  endtask

  // query, first storing whatever the window would read unwritten
  task automatic query_pixel(input int qr, input int qc);
    if (qr < img_height && qc < img_width) cover_window(qr, qc, 1'b0, '0);
    send_request(FUNC_QUERY, COORD_W'(qr), COORD_W'(qc), PIX_W'($urandom));
  endtask

  // dimension register value, mostly small images, sometimes zero or oversize
  function automatic int rand_dim();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 256;
      2:       return $urandom_range(257, 511);
      3:       return $urandom_range(1, 256);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic int pick_anchor(input int size);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return size - 1;
      default: return $urandom_range(0, size - 1);
    endcase
  endfunction

  // small images anywhere, large ones clustered around the phase anchor
  function automatic int pick_axis(input int size, input int anchor);
    int v;
    if (size <= 24) return $urandom_range(0, size - 1);
    v = anchor + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > size - 1) v = size - 1;
    return v;
  endfunction

  // result check against the oldest outstanding query
  always @(posedge clk) begin
    mean_result_t want;
    if (!rst && done) begin
      if (pending_means.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("result with no query outstanding: mean %h range flag %b",
                   mean_value, out_of_range);
      end else begin
        want = pending_means.pop_front();
        if (mean_value !== want.mean || out_of_range !== want.oor) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch at (%0d,%0d): mean exp %h got %h, range flag exp %b got %b",
                     want.qrow, want.qcol, want.mean, mean_value, want.oor, out_of_range);
        end
      end
    end
  end

  // reset values: full-white corner gives the largest mean
  task automatic test_reset_state();
    cover_window(0, 0, 1'b1, 8'hFF);
    query_pixel(0, 0);
    query_pixel(1, 1);
  endtask

  // zero width reads as one, window clipped to a 1x2 image, divisor stays 225
  task automatic test_clipped_window();
    write_register(bmfsb_pkg::REG_IMAGE_WIDTH, 9'd0);
    write_register(bmfsb_pkg::REG_IMAGE_HEIGHT, 9'd2);
    write_register(bmfsb_pkg::REG_KERNEL_RADIUS, 9'd7);
    query_pixel(0, 0);
    query_pixel(0, 1);
    query_pixel(2, 0);
  endtask

  // oversize dimensions saturate, radius from low bits, unused index ignored
  task automatic test_single_pixel_window();
    write_register(bmfsb_pkg::REG_IMAGE_WIDTH, 9'h1FF);
    write_register(bmfsb_pkg::REG_IMAGE_HEIGHT, 9'd257);
    write_register(bmfsb_pkg::REG_KERNEL_RADIUS, 9'h1F8);
    send_request(FUNC_WRITE, 8'd255, 8'd255, 8'h00);
    query_pixel(255, 255);
    send_request(FUNC_WRITE, 8'd255, 8'd0, 8'h5A);
    query_pixel(255, 0);
    write_register(REG_UNUSED, 9'h1FF);
    query_pixel(255, 255);
  endtask

  // phases of random traffic, each under its own register setting
  task automatic test_random_phases();
    int goal;
    int ops;
    int w_data;
    int h_data;
    int r_data;
    int row_anchor;
    int col_anchor;
    int choice;
    goal = requests_sent + RANDOM_ITEMS;
    while (requests_sent < goal) begin
      case (phases_run)
        0:       begin w_data = 256; h_data = 256; r_data = 7; end
        1:       begin w_data = 0;   h_data = 1;   r_data = 0; end
        2:       begin w_data = 256; h_data = 1;   r_data = 7; end
        3:       begin w_data = 1;   h_data = 256; r_data = 3; end
        4:       begin w_data = 15;  h_data = 15;  r_data = 7; end
        5:       begin w_data = 16;  h_data = 14;  r_data = 7; end
        6:       begin w_data = 300; h_data = 511; r_data = 2; end
        default: begin
          w_data = rand_dim();
          h_data = rand_dim();
          r_data = $urandom_range(0, 511);
        end
      endcase
      write_register(bmfsb_pkg::REG_IMAGE_WIDTH, DIM_W'(w_data));
      write_register(bmfsb_pkg::REG_IMAGE_HEIGHT, DIM_W'(h_data));
      write_register(bmfsb_pkg::REG_KERNEL_RADIUS, DIM_W'(r_data));
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, DIM_W'($urandom));
      row_anchor = pick_anchor(img_height);
      col_anchor = pick_anchor(img_width);
      ops        = $urandom_range(25, 60);
      while (ops > 0 && requests_sent < goal) begin
        ops--;
        if ($urandom_range(0, 29) == 0) steady_stream = !steady_stream;
        // hold off until the block has drained
        if ($urandom_range(0, 24) == 0) settle();
        choice = $urandom_range(0, 19);
        if (choice <= 10) begin
          query_pixel(pick_axis(img_height, row_anchor), pick_axis(img_width, col_anchor));
        end else if (choice <= 13) begin
          if (img_width < DEF_MAX_WIDTH && (img_height == DEF_MAX_HEIGHT || $urandom_range(0, 1)))
            query_pixel($urandom_range(0, 255), $urandom_range(img_width, 255));
          else if (img_height < DEF_MAX_HEIGHT)
            query_pixel($urandom_range(img_height, 255), $urandom_range(0, 255));
          else
            query_pixel(pick_axis(img_height, row_anchor), pick_axis(img_width, col_anchor));
        end else if (choice <= 16) begin
          send_request(FUNC_WRITE, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
        end else begin
          send_request(FUNC_WRITE, COORD_W'(pick_axis(img_height, row_anchor)),
                       COORD_W'(pick_axis(img_width, col_anchor)), PIX_W'($urandom));
        end
      end
      phases_run++;
    end
    steady_stream = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    func          = FUNC_WRITE;
    row           = '0;
    col           = '0;
    pixel         = '0;
    cfg_valid     = 1'b0;
    cfg_index     = bmfsb_pkg::REG_IMAGE_WIDTH;
    cfg_data      = '0;
    img_width     = int'(bmfsb_pkg::IMAGE_WIDTH_RST);
    img_height    = int'(bmfsb_pkg::IMAGE_HEIGHT_RST);
    win_radius    = int'(bmfsb_pkg::KERNEL_RADIUS_RST);
    fault_count   = 0;
    requests_sent = 0;
    writes_sent   = 0;
    queries_sent  = 0;
    oor_queries   = 0;
    cfg_writes    = 0;
    phases_run    = 0;
    steady_stream = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_clipped_window();
    test_single_pixel_window();
    test_random_phases();
    settle();
    repeat (300) @(posedge clk);
    if (pending_means.size() != 0) fault_count++;
    $display("ran %0d pixel writes and %0d window queries, %0d of them outside the image",
             writes_sent, queries_sent, oor_queries);
    $display("across %0d register writes in %0d random phases plus the directed settings",
             cfg_writes, phases_run);
    if (fault_count == 0) begin
      $display("box_mean_filter_shifted_border verification clean");
    end else begin
      $display("box_mean_filter_shifted_border verification failed");
    end
    $finish;
  end

endmodule
